// ----- design/sat2d_pkg.sv -----
// package for the summed-area table block
// holds sizes, register codes and the types shared by the sat2d modules other than the line ram
// no dependencies
`default_nettype none

package sat2d_pkg;

    // matrix limits
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // field and counter widths
    localparam int ELEM_W     = 32;
    localparam int SUM_W      = 52;
    localparam int REG_W      = 11;
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_CNT_W  = COL_W + 1;
    localparam int ROW_CNT_W  = ROW_W + 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register indexes
    typedef enum logic [0:0] {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    // configuration seen by the datapath
    typedef struct packed {
        logic [REG_W-1:0] columns_in_use;
        logic [REG_W-1:0] rows_in_use;
        logic             restart;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic             matrix_end;
        logic             row_end;
        logic [SUM_W-1:0] rectangle_sum;
    } t_result;

    // reset values of the size registers
    localparam logic [REG_W-1:0] COLUMNS_RESET = REG_W'(5);
    localparam logic [REG_W-1:0] ROWS_RESET    = REG_W'(4);

endpackage

`default_nettype wire

// ----- design/sat2d_cfg_regs.sv -----
// apb register file for the summed-area table sizes
// depends on sat2d_pkg
`default_nettype none

module sat2d_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sat2d_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sat2d_pkg::DATA_W-1:0]  pwdata,
    output logic      [sat2d_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output sat2d_pkg::t_cfg                    o_cfg
);

    logic [sat2d_pkg::REG_W-1:0] r_columns;
    logic [sat2d_pkg::REG_W-1:0] r_rows;
    logic                        wr_en;
    sat2d_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = sat2d_pkg::t_reg_idx'(paddr[2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= sat2d_pkg::COLUMNS_RESET;
            r_rows    <= sat2d_pkg::ROWS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                sat2d_pkg::REG_COLUMNS: r_columns <= pwdata[sat2d_pkg::REG_W-1:0];
                sat2d_pkg::REG_ROWS:    r_rows    <= pwdata[sat2d_pkg::REG_W-1:0];
                default:                r_columns <= r_columns;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            sat2d_pkg::REG_COLUMNS: prdata = sat2d_pkg::DATA_W'(r_columns);
            sat2d_pkg::REG_ROWS:    prdata = sat2d_pkg::DATA_W'(r_rows);
            default:                prdata = '0;
        endcase
    end

    // any write restarts the matrix at the origin
    assign o_cfg.columns_in_use = r_columns;
    assign o_cfg.rows_in_use    = r_rows;
    assign o_cfg.restart        = wr_en;

    // paddr low bits do not select anything
    logic unused_addr;
    assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

// ----- design/sat2d_line_ram.sv -----
// generic single-clock ram, one write and one read port, registered read
// read returns the old entry when read and write hit the same address
// no dependencies
`default_nettype none

module sat2d_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 52,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/sat2d_out_fifo.sv -----
// four-word output queue between the adder stage and the result stream
// depends on sat2d_pkg
`default_nettype none

module sat2d_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  sat2d_pkg::t_result      i_word,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output sat2d_pkg::t_result      o_word,
    output logic [2:0]              o_count
);

    sat2d_pkg::t_result r_mem [4];
    logic [1:0]         r_wr;
    logic [1:0]         r_rd;
    logic [2:0]         r_count;
    logic               do_pop;

    assign do_pop  = i_pop & (r_count != 3'd0);
    assign o_valid = (r_count != 3'd0);
    assign o_word  = r_mem[r_rd];
    assign o_count = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (do_pop) r_rd <= r_rd + 2'd1;
            r_count <= r_count + {2'd0, i_push} - {2'd0, do_pop};
        end
    end

endmodule

`default_nettype wire

// ----- design/summed_area_table_2d_top.sv -----
// top level of the streaming summed-area table (integral image)
// depends on sat2d_pkg, sat2d_cfg_regs, sat2d_line_ram, sat2d_out_fifo
`default_nettype none

// Takes one matrix element per word in row-major order and returns, for each,
// the 52-bit signed sum of the rectangle from the origin through that element.
// One element is taken every clock while the output queue has room; the line
// store is read as it is taken, and the read stage adds, writes back and
// queues the sum. The rate is set by the line store, which gives one read and
// one write each cycle; when a row is one column wide the value just written
// is forwarded to the next element. The line store is not cleared after
// reset: the first row writes every column before any later row reads it.
// A write to either size register restarts the matrix at the origin; write
// configuration only while no word is in flight.

module summed_area_table_2d_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // element stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] element_value
    input  wire logic [sat2d_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [51:0] rectangle_sum, [55:52] zero
    output logic      [sat2d_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // row_end
    output logic                                   m_axis_tlast,
    // [0] matrix_end
    output logic      [0:0]                        m_axis_tuser,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sat2d_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [sat2d_pkg::DATA_W-1:0]      pwdata,
    output logic      [sat2d_pkg::DATA_W-1:0]      prdata,
    output logic                                   pready
);

    localparam int SUM_W     = sat2d_pkg::SUM_W;
    localparam int COL_W     = sat2d_pkg::COL_W;
    localparam int ROW_W     = sat2d_pkg::ROW_W;
    localparam int COL_CNT_W = sat2d_pkg::COL_CNT_W;
    localparam int ROW_CNT_W = sat2d_pkg::ROW_CNT_W;
    localparam int ELEM_W    = sat2d_pkg::ELEM_W;

    sat2d_pkg::t_cfg    cfg;
    sat2d_pkg::t_result push_word;
    sat2d_pkg::t_result out_word;
    logic [2:0]         fifo_count;

    // position and running sum
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [SUM_W-1:0]     r_run, n_run;

    // read stage
    logic                 r_s1_valid;
    logic [COL_W-1:0]     r_s1_addr;
    logic [SUM_W-1:0]     r_s1_run;
    logic                 r_s1_first_row;
    logic                 r_s1_row_end;
    logic                 r_s1_mat_end;

    // forwarding of the word written in the cycle of the read
    logic                 r_fwd;
    logic [SUM_W-1:0]     r_wr_sum;

    logic                 accept;
    logic [COL_CNT_W-1:0] cols_eff;
    logic [ROW_CNT_W-1:0] rows_eff;
    logic [COL_W-1:0]     col_cur;
    logic [ROW_W-1:0]     row_cur;
    logic                 row_end;
    logic                 mat_end;
    logic [SUM_W-1:0]     elem_ext;
    logic [SUM_W-1:0]     run_sum;
    logic [SUM_W-1:0]     ram_rdata;
    logic [SUM_W-1:0]     above;
    logic [SUM_W-1:0]     sum;

    sat2d_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // room for every word in flight keeps the adder stage from ever stalling
    assign s_axis_tready = ({1'b0, fifo_count} + {3'd0, r_s1_valid}) < 4'd4;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // clamp the sizes: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (cfg.columns_in_use == '0) begin
            cols_eff = COL_CNT_W'(1);
        end else if (32'(cfg.columns_in_use) > 32'(sat2d_pkg::MAX_COLUMNS)) begin
            cols_eff = COL_CNT_W'(sat2d_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = COL_CNT_W'(cfg.columns_in_use);
        end
        if (cfg.rows_in_use == '0) begin
            rows_eff = ROW_CNT_W'(1);
        end else if (32'(cfg.rows_in_use) > 32'(sat2d_pkg::MAX_ROWS)) begin
            rows_eff = ROW_CNT_W'(sat2d_pkg::MAX_ROWS);
        end else begin
            rows_eff = ROW_CNT_W'(cfg.rows_in_use);
        end
    end

    // current position and end flags
    always_comb begin
        col_cur  = ({1'b0, r_col} >= cols_eff) ? '0 : r_col;
        row_cur  = ({1'b0, r_row} >= rows_eff) ? '0 : r_row;
        row_end  = (({1'b0, col_cur} + COL_CNT_W'(1)) >= cols_eff);
        mat_end  = row_end && (({1'b0, row_cur} + ROW_CNT_W'(1)) >= rows_eff);
        elem_ext = {{(SUM_W-ELEM_W){s_axis_tdata[ELEM_W-1]}}, s_axis_tdata[ELEM_W-1:0]};
        run_sum  = r_run + elem_ext;
    end

    // next position and running row sum
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_run = r_run;
        if (cfg.restart) begin
            n_col = '0;
            n_row = '0;
            n_run = '0;
        end else if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_run = '0;
                n_row = mat_end ? '0 : row_cur + ROW_W'(1);
            end else begin
                n_col = col_cur + COL_W'(1);
                n_run = run_sum;
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_run <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_run <= n_run;
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (col_cur == r_s1_addr);
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr      <= col_cur;
            r_s1_run       <= run_sum;
            r_s1_first_row <= (row_cur == '0);
            r_s1_row_end   <= row_end;
            r_s1_mat_end   <= mat_end;
        end
        if (r_s1_valid) begin
            r_wr_sum <= sum;
        end
    end

    // line store of the previous row's table values
    sat2d_line_ram #(
        .DEPTH (sat2d_pkg::MAX_COLUMNS),
        .WIDTH (SUM_W)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (sum),
        .i_re    (accept),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    // add the value above, forwarded when the same column was just written
    always_comb begin
        if (r_s1_first_row) begin
            above = '0;
        end else if (r_fwd) begin
            above = r_wr_sum;
        end else begin
            above = ram_rdata;
        end
        sum = above + r_s1_run;
    end

    assign push_word.rectangle_sum = sum;
    assign push_word.row_end       = r_s1_row_end;
    assign push_word.matrix_end    = r_s1_mat_end;

    sat2d_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_word  (push_word),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_word  (out_word),
        .o_count (fifo_count)
    );

    // result stream fields
    assign m_axis_tdata    = sat2d_pkg::OUT_DATA_W'(out_word.rectangle_sum);
    assign m_axis_tlast    = out_word.row_end;
    assign m_axis_tuser[0] = out_word.matrix_end;

endmodule

`default_nettype wire
